FILE: rtl/bec_pkg.sv
package bec_pkg;

  localparam logic KIND_BLOCK  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] ST_EXTENT  = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_COUNT   = 2'd2;

  localparam logic [1:0] REG_MERGE_DISABLE = 2'd0;
  localparam logic [1:0] REG_EXTENT_LIMIT  = 2'd1;
  localparam logic [1:0] REG_COPIES_IN_USE = 2'd2;

  localparam int FLAG_INLINE_BIT = 0;

  typedef struct packed {
    logic        kind;
    logic [1:0]  copy_index;
    logic [63:0] logical;
    logic [24:0] logical_len;
    logic [62:0] physical;
    logic [24:0] physical_len;
    logic [31:0] device_id;
    logic [5:0]  extent_flags;
    logic        at_end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_copy;
    logic [63:0] out_logical;
    logic [63:0] out_logical_len;
    logic [63:0] out_physical;
    logic [63:0] out_physical_len;
    logic [31:0] out_device;
    logic [7:0]  out_flags;
    logic [1:0]  status;
    logic [31:0] completed_count;
    logic        limit_reached;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } cfg_wr_t;

  // pending extent of one copy list; flags bit6 is the merged bit
  typedef struct packed {
    logic [63:0] logical;
    logic [63:0] logical_len;
    logic [62:0] physical;
    logic [63:0] physical_len;
    logic [31:0] device;
    logic [6:0]  flags;
  } pend_t;

endpackage

FILE: rtl/bec_stream_if.sv
interface bec_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/block_extent_coalescer_unit.sv
// Block extent coalescer.
// in_if  : block extents (kind 0) in logical order, and finish transactions (kind 1).
// out_if : completed extents, dropped overlaps and count reports; last_of_run marks
//          the final result of each input transaction.
// cfg_if : register writes (merge_disable, extent_limit, copies_in_use), always ready;
//          write only while the block is idle.
// A block extent is decided in the cycle it is accepted: merge, overlap check and
// completion are one add/compare stage, and its result (if any) is registered into
// the output queue. One block extent is taken per cycle while in_if.ready is high.
// A finish in count mode writes its one report into the output queue. A finish in
// map mode drains the pending extents, one per cycle in copy order while the queue
// has room, from the pending registers; in_if is held off until the drain ends.
// Results go through a two-entry output queue. in_if.ready depends only on registered
// state: it drops while a drain runs or when the queue holds two results the receiver
// has not taken, so a stalled receiver stops input without losing anything.
// Reset (rst_n low, synchronous) clears all pending extents, the counter, the full
// flag, the queue and the registers to their defaults.
module block_extent_coalescer_unit import bec_pkg::*; #(
  parameter int MAX_COPIES = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  bec_stream_if.sink   in_if,
  bec_stream_if.source out_if,
  bec_stream_if.sink   cfg_if
);

  localparam int         CW   = (MAX_COPIES > 1) ? $clog2(MAX_COPIES) : 1;
  localparam logic [1:0] MAXC = 2'(MAX_COPIES);

  logic                  merge_disable_r;
  logic [31:0]           extent_limit_r;
  logic [1:0]            copies_r;

  logic [MAX_COPIES-1:0] valid_r, valid_nxt;
  pend_t                 pend_r [MAX_COPIES];
  pend_t                 pend_nxt [MAX_COPIES];
  logic [31:0]           done_r, done_nxt;
  logic                  full_r, full_nxt;
  logic                  flush_r, flush_nxt;
  logic                  flush_eof_r, flush_eof_nxt;

  out_item_t             fifo_r [2];
  logic                  wptr_r, rptr_r;
  logic [1:0]            cnt_r;

  in_item_t              it;
  logic [1:0]            tracked;
  logic [CW-1:0]         ci;
  pend_t                 cur;
  logic                  cur_valid;
  logic [63:0]           pend_end, phys_end;
  logic                  overlap, can_merge, map_mode;
  logic [31:0]           done_inc;
  logic [1:0]            nvalid;
  logic [32:0]           count_sum;
  logic [CW-1:0]         sel;
  logic [MAX_COPIES-1:0] rem;
  logic                  in_fire, pop, wr_en;
  out_item_t             wr_data;

  assign it        = in_if.data;
  assign in_fire   = in_if.valid && in_if.ready;
  assign pop       = out_if.valid && out_if.ready;
  assign in_if.ready  = (cnt_r != 2'd2) && !flush_r;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = (cnt_r != 2'd0);
  assign out_if.data  = fifo_r[rptr_r];

  assign tracked   = (copies_r == 2'd0) ? 2'd1 : ((copies_r > MAXC) ? MAXC : copies_r);
  assign ci        = it.copy_index[CW-1:0];
  assign map_mode  = (extent_limit_r != 32'd0);
  assign done_inc  = (done_r == '1) ? done_r : done_r + 32'd1;

  always_comb begin
    cur       = pend_r[0];
    cur_valid = 1'b0;
    if (it.copy_index < tracked) begin
      cur       = pend_r[ci];
      cur_valid = valid_r[ci];
    end
  end

  assign pend_end  = cur.logical + cur.logical_len;
  assign phys_end  = {1'b0, cur.physical} + cur.physical_len;
  assign overlap   = cur_valid && (pend_end > it.logical);
  assign can_merge = cur_valid && !merge_disable_r && !it.extent_flags[FLAG_INLINE_BIT] &&
                     (cur.flags[5:0] == it.extent_flags) && (pend_end == it.logical) &&
                     (cur.device == it.device_id) && (phys_end == {1'b0, it.physical});

  always_comb begin
    nvalid = '0;
    sel    = '0;
    for (int i = 0; i < MAX_COPIES; i++) begin
      nvalid = nvalid + 2'(valid_r[i]);
    end
    for (int i = MAX_COPIES - 1; i >= 0; i--) begin
      if (valid_r[i]) sel = CW'(i);
    end
    rem = valid_r;
    rem[sel] = 1'b0;
    count_sum = {1'b0, done_r} + 33'(nvalid);
  end

  always_comb begin
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    done_nxt      = done_r;
    full_nxt      = full_r;
    flush_nxt     = flush_r;
    flush_eof_nxt = flush_eof_r;
    wr_en         = 1'b0;
    wr_data       = '0;

    if (flush_r) begin
      if (cnt_r != 2'd2) begin
        wr_en                    = 1'b1;
        wr_data.out_copy         = 2'(sel);
        wr_data.out_logical      = pend_r[sel].logical;
        wr_data.out_logical_len  = pend_r[sel].logical_len;
        wr_data.out_physical     = {1'b0, pend_r[sel].physical};
        wr_data.out_physical_len = pend_r[sel].physical_len;
        wr_data.out_device       = pend_r[sel].device;
        wr_data.out_flags        = {flush_eof_r && (rem == '0), pend_r[sel].flags};
        wr_data.status           = ST_EXTENT;
        wr_data.completed_count  = done_r;
        wr_data.limit_reached    = full_r;
        wr_data.last_of_run      = (rem == '0);
        valid_nxt[sel]           = 1'b0;
        if (rem == '0) begin
          flush_nxt = 1'b0;
          done_nxt  = '0;
          full_nxt  = 1'b0;
        end
      end
    end else if (in_fire) begin
      if (it.kind == KIND_FINISH) begin
        if (!map_mode) begin
          wr_en                   = 1'b1;
          wr_data.status          = ST_COUNT;
          wr_data.completed_count = count_sum[32] ? '1 : count_sum[31:0];
          wr_data.last_of_run     = 1'b1;
          valid_nxt               = '0;
          done_nxt                = '0;
          full_nxt                = 1'b0;
        end else if (valid_r != '0) begin
          flush_nxt     = 1'b1;
          flush_eof_nxt = !full_r && it.at_end_of_file;
        end else begin
          done_nxt = '0;
          full_nxt = 1'b0;
        end
      end else if ((it.copy_index < tracked) && !full_r) begin
        if (overlap) begin
          wr_en                    = 1'b1;
          wr_data.out_copy         = it.copy_index;
          wr_data.out_logical      = it.logical;
          wr_data.out_logical_len  = 64'(it.logical_len);
          wr_data.out_physical     = {1'b0, it.physical};
          wr_data.out_physical_len = 64'(it.physical_len);
          wr_data.out_device       = it.device_id;
          wr_data.out_flags        = {2'b00, it.extent_flags};
          wr_data.status           = ST_OVERLAP;
          wr_data.completed_count  = done_r;
          wr_data.limit_reached    = full_r;
          wr_data.last_of_run      = 1'b1;
        end else if (can_merge) begin
          pend_nxt[ci].logical_len  = cur.logical_len + 64'(it.logical_len);
          pend_nxt[ci].physical_len = cur.physical_len + 64'(it.physical_len);
          pend_nxt[ci].flags[6]     = 1'b1;
        end else begin
          if (cur_valid) begin
            if (!map_mode) begin
              done_nxt = done_inc;
            end else if (it.copy_index == 2'd0) begin
              done_nxt = done_inc;
              full_nxt = full_r || (done_inc >= extent_limit_r);
            end
            if (map_mode) begin
              wr_en                    = 1'b1;
              wr_data.out_copy         = it.copy_index;
              wr_data.out_logical      = cur.logical;
              wr_data.out_logical_len  = cur.logical_len;
              wr_data.out_physical     = {1'b0, cur.physical};
              wr_data.out_physical_len = cur.physical_len;
              wr_data.out_device       = cur.device;
              wr_data.out_flags        = {1'b0, cur.flags};
              wr_data.status           = ST_EXTENT;
              wr_data.completed_count  = done_nxt;
              wr_data.limit_reached    = full_nxt;
              wr_data.last_of_run      = 1'b1;
            end
          end
          valid_nxt[ci]             = 1'b1;
          pend_nxt[ci].logical      = it.logical;
          pend_nxt[ci].logical_len  = 64'(it.logical_len);
          pend_nxt[ci].physical     = it.physical;
          pend_nxt[ci].physical_len = 64'(it.physical_len);
          pend_nxt[ci].device       = it.device_id;
          pend_nxt[ci].flags        = {1'b0, it.extent_flags};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_disable_r <= 1'b0;
      extent_limit_r  <= '0;
      copies_r        <= 2'd1;
      valid_r         <= '0;
      done_r          <= '0;
      full_r          <= 1'b0;
      flush_r         <= 1'b0;
      flush_eof_r     <= 1'b0;
      wptr_r          <= 1'b0;
      rptr_r          <= 1'b0;
      cnt_r           <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.reg_index)
          REG_MERGE_DISABLE: merge_disable_r <= cfg_if.data.wdata[0];
          REG_EXTENT_LIMIT:  extent_limit_r  <= cfg_if.data.wdata;
          REG_COPIES_IN_USE: copies_r        <= cfg_if.data.wdata[1:0];
          default: ;
        endcase
      end
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      full_r      <= full_nxt;
      flush_r     <= flush_nxt;
      flush_eof_r <= flush_eof_nxt;
      if (wr_en) wptr_r <= ~wptr_r;
      if (pop)   rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (wr_en) fifo_r[wptr_r] <= wr_data;
  end

endmodule
